// File: design/bsc_pkg.sv
package bsc_pkg;

    localparam int unsigned DIV_W      = 32;
    localparam int unsigned DIV_STAGES = DIV_W;
    // S1, S2, divider, P1..P7, divider, Q1, Q2
    localparam int unsigned LAT        = 2 + DIV_STAGES + 7 + DIV_STAGES + 2;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [7:0] CFG_CAL_A = 8'd0;
    localparam logic [7:0] CFG_CAL_B = 8'd1;
    localparam logic [7:0] CFG_CAL_C = 8'd2;
    localparam logic [7:0] CFG_OSS   = 8'd3;

    localparam logic [31:0] B6_OFFSET   = 32'd4000;
    localparam logic [31:0] K_X1        = 32'd3038;
    localparam logic [31:0] K_X2        = 32'd7357;
    localparam logic [31:0] K_BIAS      = 32'd3791;
    localparam logic [31:0] K_B7        = 32'd50000;
    localparam logic [31:0] K_HALF      = 32'd32768;
    localparam logic signed [31:0] T_MAX = 32'sd32767;
    localparam logic signed [31:0] T_MIN = -32'sd32768;
    localparam logic signed [31:0] P_MAX = 32'sd262143;

    typedef struct packed {
        logic [15:0] raw_temperature;
        logic [18:0] raw_pressure;
    } t_item;

    typedef struct packed {
        logic signed [15:0] ac1;
        logic signed [15:0] ac2;
        logic signed [15:0] ac3;
        logic [15:0]        ac4;
        logic [15:0]        ac5;
        logic [15:0]        ac6;
        logic signed [15:0] b1;
        logic signed [15:0] b2;
        logic signed [15:0] mc;
        logic signed [15:0] md;
        logic [1:0]         oss;
    } t_cal;

    typedef struct packed {
        logic [31:0] x1;
        logic [18:0] up;
        logic        neg;
        logic        fault;
    } t_sb1;

    typedef struct packed {
        logic [15:0] t;
        logic        dbl;
        logic        fault;
    } t_sb2;

endpackage

// File: design/bsc_front.sv
module bsc_front import bsc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_item i_item,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_pop
);

    t_item      r_mem [QUEUE_DEPTH];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_in_ready = (r_cnt != 2'(QUEUE_DEPTH));
    assign o_valid    = (r_cnt != 2'd0);
    assign o_item     = r_mem[r_rp];
    assign push       = i_in_valid && o_in_ready;
    assign pop        = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_item;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// File: design/bsc_div.sv
module bsc_div import bsc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [DIV_W-1:0] i_num,
    input  logic [DIV_W-1:0] i_den,
    output logic [DIV_W-1:0] o_quo
);

    // one quotient bit per stage; dividend bits shift out as quotient bits shift in
    logic [DIV_W-1:0] r_rem [DIV_STAGES];
    logic [DIV_W-1:0] r_nq  [DIV_STAGES];
    logic [DIV_W-1:0] r_den [DIV_STAGES];
    logic [DIV_W-1:0] s_rem [DIV_STAGES];
    logic [DIV_W-1:0] s_nq  [DIV_STAGES];
    logic [DIV_W-1:0] s_den [DIV_STAGES];
    logic [DIV_W-1:0] n_rem [DIV_STAGES];
    logic [DIV_W-1:0] n_nq  [DIV_STAGES];
    logic [DIV_W:0]   sh    [DIV_STAGES];
    logic             ge    [DIV_STAGES];

    always_comb begin
        s_rem[0] = '0;
        s_nq[0]  = i_num;
        s_den[0] = i_den;
        for (int i = 1; i < DIV_STAGES; i++) begin
            s_rem[i] = r_rem[i-1];
            s_nq[i]  = r_nq[i-1];
            s_den[i] = r_den[i-1];
        end
        for (int i = 0; i < DIV_STAGES; i++) begin
            sh[i]    = {s_rem[i], s_nq[i][DIV_W-1]};
            ge[i]    = (sh[i] >= {1'b0, s_den[i]});
            n_rem[i] = ge[i] ? DIV_W'(sh[i] - {1'b0, s_den[i]}) : sh[i][DIV_W-1:0];
            n_nq[i]  = {s_nq[i][DIV_W-2:0], ge[i]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < DIV_STAGES; i++) begin
                r_rem[i] <= n_rem[i];
                r_nq[i]  <= n_nq[i];
                r_den[i] <= s_den[i];
            end
        end
    end

    assign o_quo = r_nq[DIV_STAGES-1];

endmodule

// File: design/bsc_back.sv
module bsc_back import bsc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cal        i_cal,
    input  logic        i_valid,
    input  t_item       i_item,
    output logic        o_pop,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_temperature_tenths,
    output logic [17:0] o_pressure_pascal,
    output logic        o_divide_fault
);

    logic           en;
    logic [LAT-1:0] r_vld;
    logic           r_out_valid, r_fault;
    logic [15:0]    r_temp;
    logic [17:0]    r_pres;

    logic [31:0] ac1e, ac2e, ac3e, ac4z, ac5z, ac6z, b1e, b2e, mce, mde;

    assign ac1e = {{16{i_cal.ac1[15]}}, i_cal.ac1};
    assign ac2e = {{16{i_cal.ac2[15]}}, i_cal.ac2};
    assign ac3e = {{16{i_cal.ac3[15]}}, i_cal.ac3};
    assign ac4z = {16'd0, i_cal.ac4};
    assign ac5z = {16'd0, i_cal.ac5};
    assign ac6z = {16'd0, i_cal.ac6};
    assign b1e  = {{16{i_cal.b1[15]}}, i_cal.b1};
    assign b2e  = {{16{i_cal.b2[15]}}, i_cal.b2};
    assign mce  = {{16{i_cal.mc[15]}}, i_cal.mc};
    assign mde  = {{16{i_cal.md[15]}}, i_cal.md};

    // whole pipeline advances together; the output register decouples the sink
    assign en    = !r_out_valid || i_out_ready;
    assign o_pop = en;

    // S1: X1
    logic [31:0] c1_d, c1_p, r1_x1;
    logic [18:0] r1_up;
    assign c1_d = {16'd0, i_item.raw_temperature} - ac6z;
    assign c1_p = c1_d * ac5z;

    // S2: signed division set up as magnitudes
    logic [31:0] c2_den, c2_num, r2_nmag, r2_dmag;
    t_sb1        r2_sb;
    assign c2_den = r1_x1 + mde;
    assign c2_num = mce << 11;

    logic [31:0] quo1;
    t_sb1        r_sb1 [DIV_STAGES];

    bsc_div u_div_t (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r2_nmag),
        .i_den (r2_dmag),
        .o_quo (quo1)
    );

    // P1: B5, T, B6
    t_sb1               sb1_o;
    logic [31:0]        c3_q, c3_b5, c3_t, r3_b6;
    logic [15:0]        c3_tsat, r3_t;
    logic [18:0]        r3_up;
    logic               r3_f;
    assign sb1_o = r_sb1[DIV_STAGES-1];
    assign c3_q  = sb1_o.neg ? 32'd0 - quo1 : quo1;
    assign c3_b5 = sb1_o.x1 + c3_q;
    assign c3_t  = 32'($signed(c3_b5 + 32'd8) >>> 4);
    always_comb begin
        if ($signed(c3_t) > T_MAX) begin
            c3_tsat = 16'(T_MAX);
        end else if ($signed(c3_t) < T_MIN) begin
            c3_tsat = 16'(T_MIN);
        end else begin
            c3_tsat = c3_t[15:0];
        end
    end

    // P2 .. P7
    logic [31:0] r4_sq, r4_m2, r4_m3;
    logic [15:0] r4_t, r5_t, r6_t, r7_t, r8_t;
    logic [18:0] r4_up, r5_up, r6_up;
    logic        r4_f, r5_f, r6_f, r7_f, r8_f;
    logic [31:0] c5_sq, r5_x1b, r5_x2b, r5_x2a, r5_x1c;
    logic [31:0] c6_x3, c6_t0, c6_x3b, r6_b3, r6_s;
    logic [31:0] c7_m, r7_b4, r7_bd;
    logic [31:0] r8_b7, r8_b4;
    logic [31:0] r9_num, r9_den;
    t_sb2        r9_sb;

    assign c5_sq  = 32'($signed(r4_sq) >>> 12);
    assign c6_x3  = r5_x1b + r5_x2a;
    assign c6_t0  = (32'(ac1e * 32'd4) + c6_x3) << i_cal.oss;
    assign c6_x3b = 32'($signed(r5_x1c + r5_x2b + 32'd2) >>> 2);
    assign c7_m   = ac4z * r6_s;

    logic [31:0] quo2;
    t_sb2        r_sb2 [DIV_STAGES];

    bsc_div u_div_p (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r9_num),
        .i_den (r9_den),
        .o_quo (quo2)
    );

    // Q1, Q2 and the output register
    t_sb2               sb2_o;
    logic [31:0]        c10_p, c10_p8, r10_p, r10_sq, r10_m;
    logic [31:0]        r11_p, r11_x1, r11_x2;
    logic [15:0]        r10_t, r11_t;
    logic               r10_f, r11_f;
    logic [31:0]        c12_sum, c12_p;
    logic [17:0]        c12_psat;
    assign sb2_o   = r_sb2[DIV_STAGES-1];
    assign c10_p   = sb2_o.dbl ? quo2 << 1 : quo2;
    assign c10_p8  = 32'($signed(c10_p) >>> 8);
    assign c12_sum = r11_x1 + r11_x2 + K_BIAS;
    assign c12_p   = r11_p + 32'($signed(c12_sum) >>> 4);
    always_comb begin
        if ($signed(c12_p) < 0) begin
            c12_psat = '0;
        end else if ($signed(c12_p) > P_MAX) begin
            c12_psat = 18'(P_MAX);
        end else begin
            c12_psat = c12_p[17:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_x1 <= 32'($signed(c1_p) >>> 15);
            r1_up <= i_item.raw_pressure;

            r2_nmag      <= c2_num[31] ? 32'd0 - c2_num : c2_num;
            r2_dmag      <= c2_den[31] ? 32'd0 - c2_den : c2_den;
            r2_sb.x1     <= r1_x1;
            r2_sb.up     <= r1_up;
            r2_sb.neg    <= c2_num[31] ^ c2_den[31];
            r2_sb.fault  <= (c2_den == 32'd0);

            r_sb1[0] <= r2_sb;
            for (int i = 1; i < DIV_STAGES; i++) begin
                r_sb1[i] <= r_sb1[i-1];
            end

            r3_b6 <= c3_b5 - B6_OFFSET;
            r3_t  <= c3_tsat;
            r3_up <= sb1_o.up;
            r3_f  <= sb1_o.fault;

            r4_sq <= r3_b6 * r3_b6;
            r4_m2 <= ac2e * r3_b6;
            r4_m3 <= ac3e * r3_b6;
            r4_t  <= r3_t;
            r4_up <= r3_up;
            r4_f  <= r3_f;

            r5_x1b <= 32'($signed(32'(b2e * c5_sq)) >>> 11);
            r5_x2b <= 32'($signed(32'(b1e * c5_sq)) >>> 16);
            r5_x2a <= 32'($signed(r4_m2) >>> 11);
            r5_x1c <= 32'($signed(r4_m3) >>> 13);
            r5_t   <= r4_t;
            r5_up  <= r4_up;
            r5_f   <= r4_f;

            r6_b3 <= 32'($signed(c6_t0 + 32'd2) >>> 2);
            r6_s  <= c6_x3b + K_HALF;
            r6_t  <= r5_t;
            r6_up <= r5_up;
            r6_f  <= r5_f;

            r7_b4 <= c7_m >> 15;
            r7_bd <= {13'd0, r6_up} - r6_b3;
            r7_t  <= r6_t;
            r7_f  <= r6_f;

            r8_b7 <= r7_bd * (K_B7 >> i_cal.oss);
            r8_b4 <= r7_b4;
            r8_t  <= r7_t;
            r8_f  <= r7_f;

            // B7 with top bit set is divided first, then doubled
            r9_num      <= r8_b7[31] ? r8_b7 : r8_b7 << 1;
            r9_den      <= r8_b4;
            r9_sb.t     <= r8_t;
            r9_sb.dbl   <= r8_b7[31];
            r9_sb.fault <= r8_f || (r8_b4 == 32'd0);

            r_sb2[0] <= r9_sb;
            for (int i = 1; i < DIV_STAGES; i++) begin
                r_sb2[i] <= r_sb2[i-1];
            end

            r10_p  <= c10_p;
            r10_sq <= c10_p8 * c10_p8;
            r10_m  <= K_X2 * c10_p;
            r10_t  <= sb2_o.t;
            r10_f  <= sb2_o.fault;

            r11_x1 <= 32'($signed(32'(r10_sq * K_X1)) >>> 16);
            r11_x2 <= 32'($signed(32'd0 - r10_m) >>> 16);
            r11_p  <= r10_p;
            r11_t  <= r10_t;
            r11_f  <= r10_f;

            r_fault <= r11_f;
            r_temp  <= r11_f ? 16'd0 : r11_t;
            r_pres  <= r11_f ? 18'd0 : c12_psat;
        end
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_vld       <= {r_vld[LAT-2:0], i_valid};
            r_out_valid <= r_vld[LAT-1];
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_temperature_tenths = r_temp;
    assign o_pressure_pascal    = r_pres;
    assign o_divide_fault       = r_fault;

    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_fault |-> r_temp == 16'd0 && r_pres == 18'd0)
        else $error("fault result carries non-zero fields");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("pipeline moved while output stalled");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && r_vld[LAT-1] |=> r_out_valid)
        else $error("item lost at output register");

endmodule

// File: design/barometric_sensor_compensation_core.sv
// Structure: 2-entry queue, 75-stage pipeline with two 32-stage radix-2 dividers,
// output register.
// Throughput: one item per cycle; the pipeline stalls as a whole only while the
// output register holds an untaken result, and the input queue still takes items while it has room.
// Reset (i_rst_n, synchronous, active low) empties the queue and pipeline and sets
// calibration to zero and oversampling to 3.
module barometric_sensor_compensation_core import bsc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_raw_temperature,
    input  logic [18:0] i_raw_pressure,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_temperature_tenths,
    output logic [17:0] o_pressure_pascal,
    output logic        o_divide_fault,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    logic [63:0] r_cal_a, r_cal_b;
    logic [31:0] r_cal_c;
    logic [1:0]  r_oss;
    t_cal        cal;
    t_item       in_item, q_item;
    logic        q_valid, pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_a <= '0;
            r_cal_b <= '0;
            r_cal_c <= '0;
            r_oss   <= 2'd3;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CAL_A: r_cal_a <= i_cfg_data;
                CFG_CAL_B: r_cal_b <= i_cfg_data;
                CFG_CAL_C: r_cal_c <= i_cfg_data[31:0];
                CFG_OSS:   r_oss   <= i_cfg_data[1:0];
                default:   r_oss   <= r_oss;
            endcase
        end
    end

    assign cal.ac1 = r_cal_a[15:0];
    assign cal.ac2 = r_cal_a[31:16];
    assign cal.ac3 = r_cal_a[47:32];
    assign cal.ac4 = r_cal_a[63:48];
    assign cal.ac5 = r_cal_b[15:0];
    assign cal.ac6 = r_cal_b[31:16];
    assign cal.b1  = r_cal_b[47:32];
    assign cal.b2  = r_cal_b[63:48];
    assign cal.mc  = r_cal_c[15:0];
    assign cal.md  = r_cal_c[31:16];
    assign cal.oss = r_oss;

    assign in_item.raw_temperature = i_raw_temperature;
    assign in_item.raw_pressure    = i_raw_pressure;

    bsc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_item     (in_item),
        .o_valid    (q_valid),
        .o_item     (q_item),
        .i_pop      (pop)
    );

    bsc_back u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cal                (cal),
        .i_valid              (q_valid),
        .i_item               (q_item),
        .o_pop                (pop),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_temperature_tenths (o_temperature_tenths),
        .o_pressure_pascal    (o_pressure_pascal),
        .o_divide_fault       (o_divide_fault)
    );

endmodule

// File: tb/sv/tb.sv
module tb import bsc_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [15:0] temp;
        logic [17:0] pres;
        logic        fault;
    } t_reading;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [15:0] i_raw_temperature;
    logic [18:0] i_raw_pressure;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [15:0] o_temperature_tenths;
    logic [17:0] o_pressure_pascal;
    logic        o_divide_fault;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index;
    logic [63:0] i_cfg_data;

    barometric_sensor_compensation_core i_dut (.*);

    // calibration shadow
    logic [63:0] cal_a, cal_b;
    logic [31:0] cal_c;
    logic [1:0]  oss_set;

    t_reading pending_readings[$];
    int  errors;
    int  send_idle_pct, recv_idle_pct;
    int  hold_off;
    longint cycle_count;

    localparam longint CYCLE_LIMIT = 400000;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [31:0] asr32(logic [31:0] v, int n);
        return $unsigned($signed(v) >>> n);
    endfunction

    function automatic logic [31:0] sdiv32(logic [31:0] a, logic [31:0] b);
        longint qa, qb;
        qa = longint'($signed(a));
        qb = longint'($signed(b));
        return 32'(qa / qb);
    endfunction

    function automatic t_reading compensate(logic [15:0] ut16, logic [18:0] up19);
        t_reading r;
        logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, ut, up;
        logic [31:0] x1, x2, x3, b3, b4, b5, b6, b7, p, t, sq, den;
        longint ts, ps;
        ac1 = {{16{cal_a[15]}}, cal_a[15:0]};
        ac2 = {{16{cal_a[31]}}, cal_a[31:16]};
        ac3 = {{16{cal_a[47]}}, cal_a[47:32]};
        ac4 = {16'd0, cal_a[63:48]};
        ac5 = {16'd0, cal_b[15:0]};
        ac6 = {16'd0, cal_b[31:16]};
        b1  = {{16{cal_b[47]}}, cal_b[47:32]};
        b2  = {{16{cal_b[63]}}, cal_b[63:48]};
        mc  = {{16{cal_c[15]}}, cal_c[15:0]};
        md  = {{16{cal_c[31]}}, cal_c[31:16]};
        ut  = {16'd0, ut16};
        up  = {13'd0, up19};
        r.temp = '0;
        r.pres = '0;
        r.fault = 1'b1;
        x1 = asr32((ut - ac6) * ac5, 15);
        den = x1 + md;
        if (den == 0) return r;
        x2 = sdiv32(mc << 11, den);
        b5 = x1 + x2;
        t = asr32(b5 + 32'd8, 4);
        b6 = b5 - B6_OFFSET;
        sq = asr32(b6 * b6, 12);
        x1 = asr32(b2 * sq, 11);
        x2 = asr32(ac2 * b6, 11);
        x3 = x1 + x2;
        b3 = asr32(((ac1 * 32'd4 + x3) << oss_set) + 32'd2, 2);
        x1 = asr32(ac3 * b6, 13);
        x2 = asr32(b1 * sq, 16);
        x3 = asr32(x1 + x2 + 32'd2, 2);
        b4 = (ac4 * (x3 + K_HALF)) >> 15;
        if (b4 == 0) return r;
        b7 = (up - b3) * (K_B7 >> oss_set);
        if (b7 < 32'h8000_0000) p = (b7 * 32'd2) / b4;
        else p = (b7 / b4) * 32'd2;
        x1 = asr32(p, 8) * asr32(p, 8);
        x1 = asr32(x1 * K_X1, 16);
        x2 = asr32(32'd0 - K_X2 * p, 16);
        p = p + asr32(x1 + x2 + K_BIAS, 4);
        ts = longint'($signed(t));
        if (ts > 32767) ts = 32767;
        if (ts < -32768) ts = -32768;
        ps = longint'($signed(p));
        if (ps < 0) ps = 0;
        if (ps > 262143) ps = 262143;
        r.temp = 16'(ts);
        r.pres = 18'(ps);
        r.fault = 1'b0;
        return r;
    endfunction

    // cycle counter / watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[barometric_sensor_compensation_core] ERROR");
            $finish;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_reading exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_readings.size() == 0) begin
                $display("%0t: unexpected result temp=%0d pres=%0d fault=%0b", $time,
                         $signed(o_temperature_tenths), o_pressure_pascal, o_divide_fault);
                errors++;
            end else begin
                exp_r = pending_readings.pop_front();
                if (o_temperature_tenths !== exp_r.temp) begin
                    $display("%0t: temperature expected %0d got %0d", $time,
                             $signed(exp_r.temp), $signed(o_temperature_tenths));
                    errors++;
                end
                if (o_pressure_pascal !== exp_r.pres) begin
                    $display("%0t: pressure expected %0d got %0d", $time,
                             exp_r.pres, o_pressure_pascal);
                    errors++;
                end
                if (o_divide_fault !== exp_r.fault) begin
                    $display("%0t: fault expected %0b got %0b", $time,
                             exp_r.fault, o_divide_fault);
                    errors++;
                end
            end
        end
    end

    // receiver ready, with an optional long hold-off
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic write_cfg(logic [7:0] idx, logic [63:0] data);
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_CAL_A: cal_a = data;
            CFG_CAL_B: cal_b = data;
            CFG_CAL_C: cal_c = data[31:0];
            CFG_OSS:   oss_set = data[1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic drain;
        i_in_valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (LAT + 10) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // offers one item; checks it against a typed-in result when given one
    task automatic send_reading(logic [15:0] ut, logic [18:0] up,
                                bit typed = 0, t_reading typed_r = '{0, 0, 0});
        t_reading pred;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_raw_temperature <= ut;
        i_raw_pressure    <= up;
        i_in_valid        <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pred = typed ? typed_r : compensate(ut, up);
        pending_readings.push_back(pred);
        // valid stays up; the next item or a drain takes it down
        @(negedge i_clk);
    endtask

    task automatic random_cal;
        write_cfg(CFG_CAL_A, {16'($urandom_range(20000, 40000)), 16'($urandom_range(0, 65535)),
                              16'($urandom), 16'($urandom_range(0, 65535))});
        write_cfg(CFG_CAL_B, {16'($urandom), 16'($urandom),
                              16'($urandom_range(20000, 30000)), 16'($urandom_range(1, 65535))});
        write_cfg(CFG_CAL_C, {32'($urandom)} | 64'h0);
    endtask

    task automatic datasheet_cal;
        write_cfg(CFG_CAL_A, {16'd15040, 16'hC6A7, 16'hFE56, 16'd408});
        write_cfg(CFG_CAL_B, {16'd4, 16'd6190, 16'd23153, 16'd32757});
        write_cfg(CFG_CAL_C, {32'h0B44_D4D0});
    endtask

    typedef struct {
        logic [15:0] ut;
        logic [18:0] up;
        bit          typed;
        t_reading    res;
    } t_stim_row;

    t_stim_row directed[] = '{
        // reset calibration: X1+MD = 0, so a temperature divide fault
        '{16'd0,     19'd0,      1, '{16'd0, 18'd0, 1'b1}},
        '{16'hFFFF,  19'h7FFFF,  1, '{16'd0, 18'd0, 1'b1}}
    };

    t_stim_row typical[] = '{
        '{16'd27898, 19'd23843,  0, '{0, 0, 0}},
        '{16'd0,     19'd0,      0, '{0, 0, 0}},
        '{16'hFFFF,  19'h7FFFF,  0, '{0, 0, 0}},
        '{16'h8000,  19'h40000,  0, '{0, 0, 0}},
        '{16'h00FF,  19'h00001,  0, '{0, 0, 0}},
        '{16'h5555,  19'h2AAAA,  0, '{0, 0, 0}},
        '{16'hAAAA,  19'h55555,  0, '{0, 0, 0}},
        '{16'd6190,  19'd40000,  0, '{0, 0, 0}}
    };

    initial begin
        int n;
        cycle_count = 0;
        errors = 0;
        hold_off = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        cal_a = '0; cal_b = '0; cal_c = '0; oss_set = 2'd3;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_out_ready = 1'b0;
        i_raw_temperature = '0;
        i_raw_pressure = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[k])
            send_reading(directed[k].ut, directed[k].up, directed[k].typed, directed[k].res);
        drain();

        // pressure divisor zero: AC4 = 0 with sane temperature path
        write_cfg(CFG_CAL_B, {16'd0, 16'd0, 16'd6190, 16'd4});
        write_cfg(CFG_CAL_C, {32'h0B44_D4D0});
        send_reading(16'd27898, 19'd23843, 1, '{16'd0, 18'd0, 1'b1});
        drain();

        // extreme calibration words: overflow paths and saturation
        write_cfg(CFG_CAL_A, 64'hFFFF_8000_7FFF_8000);
        write_cfg(CFG_CAL_B, 64'h8000_7FFF_FFFF_FFFF);
        write_cfg(CFG_CAL_C, 64'h7FFF_8000);
        foreach (typical[k]) send_reading(typical[k].ut, typical[k].up);
        drain();
        write_cfg(CFG_CAL_A, 64'h0001_7FFF_8000_7FFF);
        write_cfg(CFG_CAL_C, 64'h8000_7FFF);
        foreach (typical[k]) send_reading(typical[k].ut, typical[k].up);
        drain();

        // high index ignored, oversampling high bits dropped
        write_cfg(8'hFF, 64'h1234_5678_9ABC_DEF0);
        datasheet_cal();
        for (int o = 0; o < 4; o++) begin
            write_cfg(CFG_OSS, {62'h155, 2'(o)} | 64'hF0);
            foreach (typical[k]) send_reading(typical[k].ut, typical[k].up);
            drain();
        end

        // random phases across idling patterns
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
                1: begin send_idle_pct = 57; recv_idle_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_idle_pct = 57; end
                default: begin send_idle_pct = 28; recv_idle_pct = 28; end
            endcase
            if (ph % 2) random_cal(); else datasheet_cal();
            write_cfg(CFG_OSS, 64'($urandom_range(3)));
            if (ph == 2) hold_off = 300;
            n = 0;
            while (n < 75) begin
                if ($urandom_range(9) < 7)
                    send_reading(16'($urandom_range(20000, 36000)),
                                 19'($urandom_range(15000, 90000)));
                else
                    send_reading(16'($urandom), 19'($urandom));
                n++;
            end
            drain();
        end

        if (errors == 0) begin
            $display("[barometric_sensor_compensation_core] OK");
        end else begin
            $display("[barometric_sensor_compensation_core] ERROR");
        end
        $finish;
    end
endmodule
